// ===== rtl/xcfr_pkg.sv =====
// shared types, constants and codes of the xor-checked frame receiver
package xcfr_pkg;

  // byte store geometry
  localparam int CAPACITY = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int SUM_W    = IDX_W + 1;

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // fixed field widths
  localparam int CMD_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int STAT_W  = 3;
  localparam int COUNT_W = 6;
  localparam int CFG_W   = 1;

  // configuration register indexes
  localparam logic [CFG_W-1:0] REG_END_MARKER    = 1'b0;
  localparam logic [CFG_W-1:0] REG_TIMEOUT_LIMIT = 1'b1;

  // configuration reset values
  localparam logic [BYTE_W-1:0] END_MARKER_RST    = 8'hFF;
  localparam logic [BYTE_W-1:0] TIMEOUT_LIMIT_RST = 8'd10;
  localparam logic [BYTE_W-1:0] TICK_MAX          = 8'hFF;

  // command codes, echoed as result kind
  localparam logic [CMD_W-1:0] CMD_BYTE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DRAIN = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

  // frame status codes
  localparam logic [STAT_W-1:0] STAT_STORED   = 3'd0;
  localparam logic [STAT_W-1:0] STAT_ACCEPTED = 3'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_SUM  = 3'd2;
  localparam logic [STAT_W-1:0] STAT_DROPPED  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd4;

  // classified operation
  typedef enum logic [1:0] {
    OP_BYTE   = 2'd0,
    OP_MARKER = 2'd1,
    OP_TICK   = 2'd2,
    OP_DRAIN  = 2'd3
  } op_t;

  // head of the command queue as seen by the back end
  typedef struct packed {
    logic              valid;
    op_t               op;
    logic [BYTE_W-1:0] data;
  } q_head_t;

  // one queued item
  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] data;
  } q_item_t;

  // one result item
  typedef struct packed {
    logic [CMD_W-1:0]   kind;
    logic [STAT_W-1:0]  frame_status;
    logic               timed_out;
    logic               has_data;
    logic [BYTE_W-1:0]  data_byte;
    logic               last;
    logic [COUNT_W-1:0] committed_count;
    logic               ready_res;
  } res_t;

endpackage

// ===== rtl/xcfr_ifs.sv =====
// valid/ready channel interfaces for commands and results

interface xcfr_in_if;
  import xcfr_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

interface xcfr_out_if;
  import xcfr_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   kind;
  logic [STAT_W-1:0]  frame_status;
  logic               timed_out;
  logic               has_data;
  logic [BYTE_W-1:0]  data_byte;
  logic               last;
  logic [COUNT_W-1:0] committed_count;
  logic               ready_res;

  modport source (output valid, output kind, output frame_status, output timed_out,
                  output has_data, output data_byte, output last,
                  output committed_count, output ready_res, input ready);
  modport sink (input valid, input kind, input frame_status, input timed_out,
                input has_data, input data_byte, input last,
                input committed_count, input ready_res, output ready);
endinterface

// ===== rtl/xor_checked_frame_receiver.sv =====
// top level: configuration registers, command front end and execution back end
// a byte or tick command is queued, then its result is loaded into the output register
// throughput: one byte or tick command per cycle while the result side keeps up and no drain runs
// a drain of n committed bytes gives n results (one store read each)
// reset: control state, queue and counters clear; end marker 255, timeout limit 10
// reset: byte store contents stay undefined, no clearing pass is needed
module xor_checked_frame_receiver (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [xcfr_pkg::CFG_W-1:0]    cfg_index,
  input  logic [xcfr_pkg::BYTE_W-1:0]   cfg_data,
  xcfr_in_if.sink                       rx,
  xcfr_out_if.source                    res
);
  import xcfr_pkg::*;

  logic [BYTE_W-1:0] end_marker;
  logic [BYTE_W-1:0] timeout_limit;
  q_head_t           q;
  logic              pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      end_marker    <= END_MARKER_RST;
      timeout_limit <= TIMEOUT_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_END_MARKER:    end_marker    <= cfg_data;
        REG_TIMEOUT_LIMIT: timeout_limit <= cfg_data;
        default:           end_marker    <= end_marker;
      endcase
    end
  end

  // command classification and queue
  xcfr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .end_marker (end_marker),
    .rx         (rx),
    .q          (q),
    .pop        (pop)
  );

  // command execution and results
  xcfr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .timeout_limit (timeout_limit),
    .q             (q),
    .pop           (pop),
    .res           (res)
  );

endmodule

// ===== rtl/xcfr_ram.sv =====
// generic single-write, single-read ram with registered read data
module xcfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/xcfr_front.sv =====
// front end: accepts commands, classifies them and queues them for the back end
module xcfr_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [xcfr_pkg::BYTE_W-1:0]   end_marker,
  xcfr_in_if.sink                       rx,
  output xcfr_pkg::q_head_t             q,
  input  logic                          pop
);
  import xcfr_pkg::*;

  q_item_t             entries [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                push;
  logic                take;
  q_item_t             item;

  // accept whenever there is room; unused command is taken and discarded
  assign rx.ready = (count != QCNT_W'(QDEPTH));
  assign take     = rx.valid && rx.ready;
  assign push     = take && (rx.cmd != CMD_NONE);

  // classify the command, marker test against the current end marker
  always_comb begin
    item.data = rx.rx_byte;
    unique case (rx.cmd)
      CMD_BYTE:  item.op = (rx.rx_byte == end_marker) ? OP_MARKER : OP_BYTE;
      CMD_TICK:  item.op = OP_TICK;
      CMD_DRAIN: item.op = OP_DRAIN;
      default:   item.op = OP_TICK;
    endcase
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // head of queue to the back end
  assign q.valid = (count != '0);
  assign q.op    = entries[rd_ptr].op;
  assign q.data  = entries[rd_ptr].data;

endmodule

// ===== rtl/xcfr_back.sv =====
// back end: frame assembly, checksum test, tick counter and drain sequencing
module xcfr_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [xcfr_pkg::BYTE_W-1:0]   timeout_limit,
  input  xcfr_pkg::q_head_t             q,
  output logic                          pop,
  xcfr_out_if.source                    res
);
  import xcfr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t             state, state_next;
  logic [IDX_W-1:0]   head, head_next, head_inc;
  logic [LEN_W-1:0]   committed_len, committed_len_next;
  logic [LEN_W-1:0]   pending_len, pending_len_next;
  logic [BYTE_W-1:0]  pending_xor, pending_xor_next;
  logic [BYTE_W-1:0]  tick_count, tick_count_next;
  logic [LEN_W-1:0]   fill;
  logic               store_full;
  logic [SUM_W-1:0]   wr_sum;
  logic               can_load;
  logic               load;
  res_t               res_next;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [BYTE_W-1:0]  ram_rdata;

  // byte store: circular, committed bytes start at head, pending follow
  xcfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (q.data),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // store occupancy and write slot
  assign fill       = committed_len + pending_len;
  assign store_full = (fill >= LEN_W'(CAPACITY));
  assign wr_sum     = SUM_W'(head) + SUM_W'(fill);
  assign ram_waddr  = (wr_sum >= SUM_W'(CAPACITY)) ? IDX_W'(wr_sum - SUM_W'(CAPACITY))
                                                   : IDX_W'(wr_sum);
  assign head_inc   = (head == IDX_W'(CAPACITY - 1)) ? '0 : head + 1'b1;

  // output register can take a new result
  assign can_load = !res.valid || res.ready;

  // command execution
  always_comb begin
    state_next         = state;
    head_next          = head;
    committed_len_next = committed_len;
    pending_len_next   = pending_len;
    pending_xor_next   = pending_xor;
    tick_count_next    = tick_count;
    pop                = 1'b0;
    load               = 1'b0;
    ram_we             = 1'b0;
    ram_re             = 1'b0;
    ram_raddr          = head;

    res_next.kind            = CMD_BYTE;
    res_next.frame_status    = STAT_STORED;
    res_next.timed_out       = 1'b0;
    res_next.has_data        = 1'b0;
    res_next.data_byte       = '0;
    res_next.last            = 1'b1;
    res_next.committed_count = COUNT_W'(committed_len);
    res_next.ready_res       = (committed_len != '0);

    unique case (state)
      ST_IDLE: begin
        if (q.valid && can_load) begin
          pop  = 1'b1;
          load = 1'b1;
          unique case (q.op)
            OP_BYTE: begin
              if (!store_full) begin
                ram_we           = 1'b1;
                pending_len_next = pending_len + 1'b1;
                pending_xor_next = pending_xor ^ q.data;
              end else begin
                res_next.frame_status = STAT_DROPPED;
              end
            end
            OP_MARKER: begin
              if (pending_len == '0) begin
                res_next.frame_status = STAT_EMPTY;
              end else if (pending_xor == '0) begin
                committed_len_next    = committed_len + pending_len - 1'b1;
                tick_count_next       = '0;
                res_next.frame_status = STAT_ACCEPTED;
              end else begin
                res_next.frame_status = STAT_BAD_SUM;
              end
              pending_len_next = '0;
              pending_xor_next = '0;
            end
            OP_TICK: begin
              if (tick_count != TICK_MAX) begin
                tick_count_next = tick_count + 1'b1;
              end
              res_next.kind      = CMD_TICK;
              res_next.timed_out = (tick_count_next > timeout_limit);
            end
            OP_DRAIN: begin
              res_next.kind = CMD_DRAIN;
              if (committed_len != '0) begin
                // first byte read now, results follow from the drain state
                load       = 1'b0;
                ram_re     = 1'b1;
                state_next = ST_DRAIN;
              end
            end
            default: begin
              load = 1'b0;
            end
          endcase
        end
      end
      ST_DRAIN: begin
        res_next.kind      = CMD_DRAIN;
        res_next.has_data  = 1'b1;
        res_next.data_byte = ram_rdata;
        res_next.last      = (committed_len == LEN_W'(1));
        if (can_load) begin
          load               = 1'b1;
          head_next          = head_inc;
          committed_len_next = committed_len - 1'b1;
          if (committed_len == LEN_W'(1)) begin
            state_next = ST_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = head_inc;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      head          <= '0;
      committed_len <= '0;
      pending_len   <= '0;
      pending_xor   <= '0;
      tick_count    <= '0;
      res.valid     <= 1'b0;
    end else begin
      state         <= state_next;
      head          <= head_next;
      committed_len <= committed_len_next;
      pending_len   <= pending_len_next;
      pending_xor   <= pending_xor_next;
      tick_count    <= tick_count_next;
      if (load) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    if (load) begin
      res.kind            <= res_next.kind;
      res.frame_status    <= res_next.frame_status;
      res.timed_out       <= res_next.timed_out;
      res.has_data        <= res_next.has_data;
      res.data_byte       <= res_next.data_byte;
      res.last            <= res_next.last;
      res.committed_count <= res_next.committed_count;
      res.ready_res       <= res_next.ready_res;
    end
  end

  // store never overfills
  assert property (@(posedge clk) disable iff (rst)
    fill <= LEN_W'(CAPACITY))
    else $error("byte store overfilled");

  // drain sequencing only runs with committed bytes left
  assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAIN |-> committed_len != '0)
    else $error("drain state with no committed bytes");

  // empty pending frame carries no checksum residue
  assert property (@(posedge clk) disable iff (rst)
    pending_len == '0 |-> pending_xor == '0)
    else $error("pending checksum without pending bytes");

  // data-bearing results are drain results with bytes held
  assert property (@(posedge clk) disable iff (rst)
    res.valid && res.has_data |-> res.kind == CMD_DRAIN && res.ready_res)
    else $error("data byte on a non-drain result");

  // no byte is stored while a drain walks the store
  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == ST_IDLE && !ram_re)
    else $error("store write during drain");

endmodule

// ===== sim/tb_xor_checked_frame_receiver.sv =====
// self-checking testbench of the xor-checked frame receiver
module tb_xor_checked_frame_receiver;
  timeunit 1ns;
  timeprecision 1ps;

  import xcfr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int PHASE_ITEMS = 14;
  localparam int SETTLE_CYCLES = 8;

  // one row of the directed stimulus, with an optional typed-in expectation
  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] data;
    bit                typed;
    logic [STAT_W-1:0] status;
    bit                tmo;
    bit                has;
  } row_t;

  row_t rows [25] = '{
    '{CMD_DRAIN, 8'h00, 1'b1, STAT_STORED,   1'b0, 1'b0},
    '{CMD_BYTE,  8'hFF, 1'b1, STAT_EMPTY,    1'b0, 1'b0},
    '{CMD_BYTE,  8'h00, 1'b1, STAT_STORED,   1'b0, 1'b0},
    '{CMD_BYTE,  8'hFF, 1'b1, STAT_ACCEPTED, 1'b0, 1'b0},
    '{CMD_BYTE,  8'h12, 1'b0, STAT_STORED,   1'b0, 1'b0},
    '{CMD_BYTE,  8'h34, 1'b0, STAT_STORED,   1'b0, 1'b0},
    '{CMD_BYTE,  8'h26, 1'b0, STAT_STORED,   1'b0, 1'b0},
    '{CMD_BYTE,  8'hFF, 1'b1, STAT_ACCEPTED, 1'b0, 1'b0},
    '{CMD_BYTE,  8'h01, 1'b0, STAT_STORED,   1'b0, 1'b0},
    '{CMD_BYTE,  8'h02, 1'b0, STAT_STORED,   1'b0, 1'b0},
    '{CMD_BYTE,  8'hFF, 1'b1, STAT_BAD_SUM,  1'b0, 1'b0},
    '{CMD_TICK,  8'h00, 1'b1, STAT_STORED,   1'b0, 1'b0},
    '{CMD_NONE,  8'h55, 1'b0, STAT_STORED,   1'b0, 1'b0},
    '{CMD_BYTE,  8'h80, 1'b0, STAT_STORED,   1'b0, 1'b0},
    '{CMD_BYTE,  8'h01, 1'b0, STAT_STORED,   1'b0, 1'b0},
    '{CMD_BYTE,  8'h81, 1'b0, STAT_STORED,   1'b0, 1'b0},
    '{CMD_BYTE,  8'hFF, 1'b1, STAT_ACCEPTED, 1'b0, 1'b0},
    '{CMD_BYTE,  8'hFE, 1'b0, STAT_STORED,   1'b0, 1'b0},
    '{CMD_BYTE,  8'hFE, 1'b0, STAT_STORED,   1'b0, 1'b0},
    '{CMD_BYTE,  8'hFF, 1'b1, STAT_ACCEPTED, 1'b0, 1'b0},
    '{CMD_BYTE,  8'h3C, 1'b0, STAT_STORED,   1'b0, 1'b0},
    '{CMD_DRAIN, 8'hA5, 1'b0, STAT_STORED,   1'b0, 1'b0},
    '{CMD_BYTE,  8'h3C, 1'b0, STAT_STORED,   1'b0, 1'b0},
    '{CMD_BYTE,  8'hFF, 1'b1, STAT_ACCEPTED, 1'b0, 1'b0},
    '{CMD_DRAIN, 8'h00, 1'b0, STAT_STORED,   1'b0, 1'b0}
  };

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [CFG_W-1:0]  cfg_index;
  logic [BYTE_W-1:0] cfg_data;

  xcfr_in_if  rx_if ();
  xcfr_out_if res_if ();

  xor_checked_frame_receiver dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx        (rx_if),
    .res       (res_if)
  );

  // receiver state mirror
  logic [BYTE_W-1:0] m_store [CAPACITY];
  int                m_committed;
  int                m_pending;
  logic [BYTE_W-1:0] m_xor;
  int                m_ticks;
  logic [BYTE_W-1:0] m_marker;
  logic [BYTE_W-1:0] m_limit;

  res_t        due_results [$];
  int          mismatches;
  int          sent_items;
  bit          calm;
  int unsigned cycle_count;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("xor_checked_frame_receiver verification failed");
        $finish;
      end
    end
  end

  task automatic report(input string msg);
    mismatches++;
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // advance the mirror by one accepted command and queue the results it causes
  task automatic step_receiver(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data);
    res_t r;
    int   n;
    r = '0;
    r.kind = cmd;
    r.last = 1'b1;
    r.committed_count = COUNT_W'(m_committed);
    r.ready_res = (m_committed != 0);
    case (cmd)
      CMD_BYTE: begin
        if (data == m_marker) begin
          if (m_pending == 0) begin
            r.frame_status = STAT_EMPTY;
          end else if (m_xor == '0) begin
            m_committed += m_pending - 1;
            m_ticks = 0;
            r.frame_status = STAT_ACCEPTED;
          end else begin
            r.frame_status = STAT_BAD_SUM;
          end
          m_pending = 0;
          m_xor = '0;
        end else if (m_committed + m_pending < CAPACITY) begin
          m_store[m_committed + m_pending] = data;
          m_pending++;
          m_xor ^= data;
          r.frame_status = STAT_STORED;
        end else begin
          r.frame_status = STAT_DROPPED;
        end
        due_results.push_back(r);
      end
      CMD_TICK: begin
        if (m_ticks < 255) m_ticks++;
        r.timed_out = (m_ticks > int'(m_limit));
        due_results.push_back(r);
      end
      CMD_DRAIN: begin
        n = m_committed;
        if (n == 0) begin
          due_results.push_back(r);
        end else begin
          for (int i = 0; i < n; i++) begin
            r.has_data = 1'b1;
            r.data_byte = m_store[i];
            r.last = (i + 1 == n);
            r.committed_count = COUNT_W'(n - i);
            r.ready_res = 1'b1;
            due_results.push_back(r);
          end
        end
        // partial frame moves to the front of the store
        for (int i = 0; i < m_pending; i++) m_store[i] = m_store[n + i];
        m_committed = 0;
      end
      default: begin
        // unused command: no result, no state change
      end
    endcase
  endtask

  // one command transfer, after a random gap
  task automatic send(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_if.valid <= 1'b1;
    rx_if.cmd <= cmd;
    rx_if.rx_byte <= data;
    do @(posedge clk); while (!rx_if.ready);
    step_receiver(cmd, data);
    if (cmd != CMD_NONE) sent_items++;
  endtask

  // hold off the sender until every expected result is in, then let the block go quiet
  task automatic settle();
    rx_if.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [BYTE_W-1:0] marker, input logic [BYTE_W-1:0] limit);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= REG_END_MARKER;
    cfg_data <= marker;
    @(posedge clk);
    m_marker = marker;
    cfg_index <= REG_TIMEOUT_LIMIT;
    cfg_data <= limit;
    @(posedge clk);
    m_limit = limit;
    cfg_we <= 1'b0;
  endtask

  // a frame of len bytes closed by the marker; the last byte is the checksum
  task automatic send_frame(input int len, input bit corrupt);
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] sum;
    sum = '0;
    for (int i = 0; i < len - 1; i++) begin
      do b = 8'($urandom_range(0, 255)); while (b == m_marker);
      send(CMD_BYTE, b);
      sum ^= b;
    end
    if (corrupt) sum ^= 8'($urandom_range(1, 255));
    if (len > 0) send(CMD_BYTE, sum);
    send(CMD_BYTE, m_marker);
  endtask

  // one random sequence: mostly well-formed frames, plus ticks, drains and noise
  task automatic run_sequence();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 36) : $urandom_range(1, 6);
    if (pick < 60) begin
      send_frame(len, 1'b0);
    end else if (pick < 75) begin
      send_frame(len, 1'b1);
    end else if (pick < 85) begin
      repeat ($urandom_range(1, 15)) send(CMD_TICK, 8'($urandom_range(0, 255)));
    end else if (pick < 95) begin
      send(CMD_DRAIN, 8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 4))
        send(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    end
  endtask

  // result side: random stalls, every transfer checked against the oldest expectation
  initial begin
    int   stall;
    res_t got;
    res_t want;
    @(negedge rst);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
      got = '{kind: res_if.kind, frame_status: res_if.frame_status,
              timed_out: res_if.timed_out, has_data: res_if.has_data,
              data_byte: res_if.data_byte, last: res_if.last,
              committed_count: res_if.committed_count, ready_res: res_if.ready_res};
      if (due_results.size() == 0) begin
        report($sformatf("result with nothing expected, kind %0d", got.kind));
      end else begin
        want = due_results.pop_front();
        if (got.kind != want.kind)
          report($sformatf("kind %0d, want %0d", got.kind, want.kind));
        if (got.frame_status != want.frame_status)
          report($sformatf("frame_status %0d, want %0d", got.frame_status, want.frame_status));
        if (got.timed_out != want.timed_out)
          report($sformatf("timed_out %0d, want %0d", got.timed_out, want.timed_out));
        if (got.has_data != want.has_data)
          report($sformatf("has_data %0d, want %0d", got.has_data, want.has_data));
        if (got.data_byte != want.data_byte)
          report($sformatf("data_byte %02h, want %02h", got.data_byte, want.data_byte));
        if (got.last != want.last)
          report($sformatf("last %0d, want %0d", got.last, want.last));
        if (got.committed_count != want.committed_count)
          report($sformatf("committed_count %0d, want %0d",
                           got.committed_count, want.committed_count));
        if (got.ready_res != want.ready_res)
          report($sformatf("ready_res %0d, want %0d", got.ready_res, want.ready_res));
      end
    end
  end

  // stimulus
  initial begin
    int target;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_END_MARKER;
    cfg_data <= '0;
    rx_if.valid <= 1'b0;
    rx_if.cmd <= CMD_BYTE;
    rx_if.rx_byte <= '0;
    res_if.ready <= 1'b0;
    calm = 1'b0;
    mismatches = 0;
    sent_items = 0;
    m_committed = 0;
    m_pending = 0;
    m_xor = '0;
    m_ticks = 0;
    m_marker = END_MARKER_RST;
    m_limit = TIMEOUT_LIMIT_RST;
    foreach (m_store[i]) m_store[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows under the reset configuration
    for (int i = 0; i < $size(rows); i++) begin
      send(rows[i].cmd, rows[i].data);
      if (rows[i].typed) begin
        due_results[due_results.size() - 1].frame_status = rows[i].status;
        due_results[due_results.size() - 1].timed_out = rows[i].tmo;
        due_results[due_results.size() - 1].has_data = rows[i].has;
      end
    end

    // random phases, each under its own configuration
    for (int p = 0; p < 5; p++) begin
      case (p)
        1: write_config(8'h00, 8'd0);
        2: write_config(8'h7E, 8'd255);
        3: write_config(8'h80, 8'd3);
        4: write_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        default: ;
      endcase
      calm = (p == 2);
      target = sent_items + PHASE_ITEMS;
      while (sent_items < target) run_sequence();
    end

    // tick counter saturation, first at the limit then above it
    write_config(8'hFF, 8'd255);
    calm = 1'b1;
    repeat (256) send(CMD_TICK, 8'($urandom_range(0, 255)));
    write_config(8'hFF, 8'd254);
    calm = 1'b0;
    repeat (3) send(CMD_TICK, 8'($urandom_range(0, 255)));
    repeat (4) run_sequence();
    send(CMD_DRAIN, 8'h00);

    settle();
    if (mismatches == 0) begin
      $display("xor_checked_frame_receiver verification clean");
    end else begin
      $display("xor_checked_frame_receiver verification failed");
    end
    $finish;
  end

endmodule
